// ===== rtl/tbvi_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tbvi_pkg
// Shared types, constants and the multiply-accumulate program of the
// triangle barycentric velocity interpolator.
// ----------------------------------------------------------------------------
package tbvi_pkg;

  localparam int WGT_BITS = 17;
  localparam int WGT_FRAC = 16;
  localparam logic [WGT_BITS-1:0] WGT_ONE = 17'h10000;
  localparam int RND_HALF = 32768;
  localparam int K_BITS = 6;
  localparam logic [K_BITS-1:0] K_VEL_FIRST = 6'd27;
  localparam logic [K_BITS-1:0] K_LAST = 6'd35;
  localparam logic [1:0] CORNER_NONE = 2'd3;

  typedef enum logic [1:0] {
    CMD_LOAD_POS = 2'd0,
    CMD_LOAD_VEL = 2'd1,
    CMD_INTERP   = 2'd2
  } cmd_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL,
    ST_ACC,
    ST_CHECK,
    ST_DSUB,
    ST_DCHK,
    ST_DIT,
    ST_WFIN,
    ST_RND,
    ST_DONE
  } state_e;

  // multiplicand groups
  typedef enum logic [1:0] {
    AG_E1,
    AG_N,
    AG_M,
    AG_U
  } a_grp_e;

  // multiplier groups
  typedef enum logic [2:0] {
    BG_E2,
    BG_N,
    BG_F,
    BG_P0,
    BG_P1,
    BG_W
  } b_grp_e;

  typedef enum logic [2:0] {
    DS_N,
    DS_NSQ,
    DS_M,
    DS_NUM,
    DS_VEL
  } dst_e;

  typedef struct packed {
    a_grp_e     a_grp;
    logic [1:0] a_idx;
    logic [1:0] a_cor;
    b_grp_e     b_grp;
    logic [1:0] b_idx;
    logic       neg;
    logic       clr;
    logic       wr;
    dst_e       dst;
    logic [1:0] d_idx;
  } uop_t;

  function automatic uop_t mk(a_grp_e ag, logic [1:0] ai, logic [1:0] ac, b_grp_e bg,
                              logic [1:0] bi, logic ng, logic cl, logic w, dst_e d,
                              logic [1:0] di);
    uop_t u;
    u.a_grp = ag;
    u.a_idx = ai;
    u.a_cor = ac;
    u.b_grp = bg;
    u.b_idx = bi;
    u.neg   = ng;
    u.clr   = cl;
    u.wr    = w;
    u.dst   = d;
    u.d_idx = di;
    return u;
  endfunction

  // one entry per product term: clr opens a sum, wr closes it
  function automatic uop_t uop_at(logic [K_BITS-1:0] k);
    uop_t u;
    case (k)
      // normal n = e1 x e2
      6'd0:  u = mk(AG_E1, 2'd1, 2'd0, BG_E2, 2'd2, 1'b0, 1'b1, 1'b0, DS_N, 2'd0);
      6'd1:  u = mk(AG_E1, 2'd2, 2'd0, BG_E2, 2'd1, 1'b1, 1'b0, 1'b1, DS_N, 2'd0);
      6'd2:  u = mk(AG_E1, 2'd2, 2'd0, BG_E2, 2'd0, 1'b0, 1'b1, 1'b0, DS_N, 2'd1);
      6'd3:  u = mk(AG_E1, 2'd0, 2'd0, BG_E2, 2'd2, 1'b1, 1'b0, 1'b1, DS_N, 2'd1);
      6'd4:  u = mk(AG_E1, 2'd0, 2'd0, BG_E2, 2'd1, 1'b0, 1'b1, 1'b0, DS_N, 2'd2);
      6'd5:  u = mk(AG_E1, 2'd1, 2'd0, BG_E2, 2'd0, 1'b1, 1'b0, 1'b1, DS_N, 2'd2);
      // squared length
      6'd6:  u = mk(AG_N, 2'd0, 2'd0, BG_N, 2'd0, 1'b0, 1'b1, 1'b0, DS_NSQ, 2'd0);
      6'd7:  u = mk(AG_N, 2'd1, 2'd0, BG_N, 2'd1, 1'b0, 1'b0, 1'b0, DS_NSQ, 2'd0);
      6'd8:  u = mk(AG_N, 2'd2, 2'd0, BG_N, 2'd2, 1'b0, 1'b0, 1'b1, DS_NSQ, 2'd0);
      // m = n x (x1 - x2)
      6'd9:  u = mk(AG_N, 2'd1, 2'd0, BG_F, 2'd2, 1'b0, 1'b1, 1'b0, DS_M, 2'd0);
      6'd10: u = mk(AG_N, 2'd2, 2'd0, BG_F, 2'd1, 1'b1, 1'b0, 1'b1, DS_M, 2'd0);
      6'd11: u = mk(AG_N, 2'd2, 2'd0, BG_F, 2'd0, 1'b0, 1'b1, 1'b0, DS_M, 2'd1);
      6'd12: u = mk(AG_N, 2'd0, 2'd0, BG_F, 2'd2, 1'b1, 1'b0, 1'b1, DS_M, 2'd1);
      6'd13: u = mk(AG_N, 2'd0, 2'd0, BG_F, 2'd1, 1'b0, 1'b1, 1'b0, DS_M, 2'd2);
      6'd14: u = mk(AG_N, 2'd1, 2'd0, BG_F, 2'd0, 1'b1, 1'b0, 1'b1, DS_M, 2'd2);
      // numerator of corner 0
      6'd15: u = mk(AG_M, 2'd0, 2'd0, BG_P0, 2'd0, 1'b0, 1'b1, 1'b0, DS_NUM, 2'd0);
      6'd16: u = mk(AG_M, 2'd1, 2'd0, BG_P0, 2'd1, 1'b0, 1'b0, 1'b0, DS_NUM, 2'd0);
      6'd17: u = mk(AG_M, 2'd2, 2'd0, BG_P0, 2'd2, 1'b0, 1'b0, 1'b1, DS_NUM, 2'd0);
      // m = n x (x2 - x0)
      6'd18: u = mk(AG_N, 2'd1, 2'd0, BG_E2, 2'd2, 1'b0, 1'b1, 1'b0, DS_M, 2'd0);
      6'd19: u = mk(AG_N, 2'd2, 2'd0, BG_E2, 2'd1, 1'b1, 1'b0, 1'b1, DS_M, 2'd0);
      6'd20: u = mk(AG_N, 2'd2, 2'd0, BG_E2, 2'd0, 1'b0, 1'b1, 1'b0, DS_M, 2'd1);
      6'd21: u = mk(AG_N, 2'd0, 2'd0, BG_E2, 2'd2, 1'b1, 1'b0, 1'b1, DS_M, 2'd1);
      6'd22: u = mk(AG_N, 2'd0, 2'd0, BG_E2, 2'd1, 1'b0, 1'b1, 1'b0, DS_M, 2'd2);
      6'd23: u = mk(AG_N, 2'd1, 2'd0, BG_E2, 2'd0, 1'b1, 1'b0, 1'b1, DS_M, 2'd2);
      // numerator of corner 1
      6'd24: u = mk(AG_M, 2'd0, 2'd0, BG_P1, 2'd0, 1'b0, 1'b1, 1'b0, DS_NUM, 2'd1);
      6'd25: u = mk(AG_M, 2'd1, 2'd0, BG_P1, 2'd1, 1'b0, 1'b0, 1'b0, DS_NUM, 2'd1);
      6'd26: u = mk(AG_M, 2'd2, 2'd0, BG_P1, 2'd2, 1'b0, 1'b0, 1'b1, DS_NUM, 2'd1);
      // weighted velocity, one component at a time
      6'd27: u = mk(AG_U, 2'd0, 2'd0, BG_W, 2'd0, 1'b0, 1'b1, 1'b0, DS_VEL, 2'd0);
      6'd28: u = mk(AG_U, 2'd0, 2'd1, BG_W, 2'd1, 1'b0, 1'b0, 1'b0, DS_VEL, 2'd0);
      6'd29: u = mk(AG_U, 2'd0, 2'd2, BG_W, 2'd2, 1'b0, 1'b0, 1'b1, DS_VEL, 2'd0);
      6'd30: u = mk(AG_U, 2'd1, 2'd0, BG_W, 2'd0, 1'b0, 1'b1, 1'b0, DS_VEL, 2'd1);
      6'd31: u = mk(AG_U, 2'd1, 2'd1, BG_W, 2'd1, 1'b0, 1'b0, 1'b0, DS_VEL, 2'd1);
      6'd32: u = mk(AG_U, 2'd1, 2'd2, BG_W, 2'd2, 1'b0, 1'b0, 1'b1, DS_VEL, 2'd1);
      6'd33: u = mk(AG_U, 2'd2, 2'd0, BG_W, 2'd0, 1'b0, 1'b1, 1'b0, DS_VEL, 2'd2);
      6'd34: u = mk(AG_U, 2'd2, 2'd1, BG_W, 2'd1, 1'b0, 1'b0, 1'b0, DS_VEL, 2'd2);
      6'd35: u = mk(AG_U, 2'd2, 2'd2, BG_W, 2'd2, 1'b0, 1'b0, 1'b1, DS_VEL, 2'd2);
      default: u = mk(AG_E1, 2'd0, 2'd0, BG_E2, 2'd0, 1'b0, 1'b1, 1'b0, DS_N, 2'd0);
    endcase
    return u;
  endfunction

endpackage

// ===== rtl/triangle_barycentric_velocity_interp_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// triangle_barycentric_velocity_interp_top
// Triangle corner store and barycentric velocity interpolator built around
// one bit-serial multiply-accumulate adder.
// ----------------------------------------------------------------------------
// Loads are written to the corner store when accepted. An interpolate request
// runs as a sequence of signed bit-serial products, all through one wide
// adder, each product followed by an accumulate step: 24 products with an
// edge or point difference as multiplier, 3 for the squared normal length
// and 9 for the velocity blend, plus two weight divisions of up to 16 steps
// each. A zero-area triangle ends after the squared normal length.
// The input stalls while a request is worked on; a finished result waits in
// the output register, so the next request can be taken before it is read.
// ----------------------------------------------------------------------------
module triangle_barycentric_velocity_interp_top
  import tbvi_pkg::*;
#(
  parameter int COORD_BITS = 32
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic [1:0]            command_i,
  input  logic [1:0]            corner_i,
  input  logic [COORD_BITS-1:0] coord_x_i,
  input  logic [COORD_BITS-1:0] coord_y_i,
  input  logic [COORD_BITS-1:0] coord_z_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic [COORD_BITS-1:0] vel_x_o,
  output logic [COORD_BITS-1:0] vel_y_o,
  output logic [COORD_BITS-1:0] vel_z_o,
  output logic [WGT_BITS-1:0]   weight_a_o,
  output logic [WGT_BITS-1:0]   weight_b_o,
  output logic [WGT_BITS-1:0]   weight_c_o,
  output logic                  degenerate_o
);

  localparam int C  = COORD_BITS;
  localparam int D  = C + 1;
  localparam int NW = 2 * D + 1;
  localparam int MW = NW + D + 1;
  localparam int AW = 2 * NW + 4;
  localparam int IW = $clog2(NW);
  localparam int SW = AW - WGT_FRAC;

  state_e state_q, state_d;

  logic [C-1:0]  pos_q [3][3];
  logic [C-1:0]  vst_q [3][3];
  logic [C-1:0]  p_q   [3];
  logic [D-1:0]  e1 [3];
  logic [D-1:0]  e2 [3];
  logic [D-1:0]  fd [3];
  logic [D-1:0]  px0 [3];
  logic [D-1:0]  px1 [3];

  logic [NW-1:0] n_q [3];
  logic [MW-1:0] m_q [3];
  logic [AW-1:0] nsq_q, acc_q, prod_q;
  logic [AW-1:0] num_q [2];

  logic [K_BITS-1:0]   k_q, k_d;
  logic [IW-1:0]       idx_q, idx_d, idx_top;
  logic                first_q, first_d;
  logic                div_sel_q, div_sel_d;
  logic [3:0]          cnt_q, cnt_d;
  logic [WGT_FRAC-1:0] quo_q, quo_d;
  logic [WGT_BITS-1:0] wa_q, wb_q, wc_q, wsel, wb_lim, wb_new;
  logic [C-1:0]        vel_q [3];
  logic                deg_q;

  logic [C-1:0]        ovel_q [3];
  logic [WGT_BITS-1:0] owa_q, owb_q, owc_q;
  logic                odeg_q;
  logic                out_valid_q, out_valid_d;

  uop_t          uop, uop_nxt;
  logic [AW-1:0] a_op, add_a, add_b, sum, num_sel;
  logic [NW-1:0] b_op;
  logic          b_bit, cin;
  logic          in_acc, enter_mul, out_load;
  logic          nsq_zero, num_le0, rem_le0;
  logic [SW-1:0] shifted;
  logic [C-1:0]  vsat;

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign out_load   = (state_q == ST_DONE) && (!out_valid_q || !out_stall_i);

  // edge vectors, all exact at one bit wider than a coordinate
  always_comb begin
    for (int c = 0; c < 3; c++) begin
      e1[c]  = {pos_q[1][c][C-1], pos_q[1][c]} - {pos_q[0][c][C-1], pos_q[0][c]};
      e2[c]  = {pos_q[2][c][C-1], pos_q[2][c]} - {pos_q[0][c][C-1], pos_q[0][c]};
      fd[c]  = {pos_q[1][c][C-1], pos_q[1][c]} - {pos_q[2][c][C-1], pos_q[2][c]};
      px0[c] = {p_q[c][C-1], p_q[c]} - {pos_q[0][c][C-1], pos_q[0][c]};
      px1[c] = {p_q[c][C-1], p_q[c]} - {pos_q[1][c][C-1], pos_q[1][c]};
    end
  end

  assign uop      = uop_at(k_q);
  assign uop_nxt  = uop_at(k_d);
  assign nsq_zero = (nsq_q == '0);
  assign num_sel  = div_sel_q ? num_q[1] : num_q[0];
  assign num_le0  = num_sel[AW-1] || (num_sel == '0);
  assign rem_le0  = acc_q[AW-1] || (acc_q == '0);

  // operand selection
  always_comb begin
    case (uop.b_idx)
      2'd0:    wsel = wa_q;
      2'd1:    wsel = wb_q;
      default: wsel = wc_q;
    endcase
    case (uop.a_grp)
      AG_E1:   a_op = {{(AW-D){e1[uop.a_idx][D-1]}}, e1[uop.a_idx]};
      AG_N:    a_op = {{(AW-NW){n_q[uop.a_idx][NW-1]}}, n_q[uop.a_idx]};
      AG_M:    a_op = {{(AW-MW){m_q[uop.a_idx][MW-1]}}, m_q[uop.a_idx]};
      AG_U:    a_op = {{(AW-C){vst_q[uop.a_cor][uop.a_idx][C-1]}},
                       vst_q[uop.a_cor][uop.a_idx]};
      default: a_op = '0;
    endcase
    case (uop.b_grp)
      BG_E2:   b_op = {{(NW-D){e2[uop.b_idx][D-1]}}, e2[uop.b_idx]};
      BG_N:    b_op = n_q[uop.b_idx];
      BG_F:    b_op = {{(NW-D){fd[uop.b_idx][D-1]}}, fd[uop.b_idx]};
      BG_P0:   b_op = {{(NW-D){px0[uop.b_idx][D-1]}}, px0[uop.b_idx]};
      BG_P1:   b_op = {{(NW-D){px1[uop.b_idx][D-1]}}, px1[uop.b_idx]};
      BG_W:    b_op = {{(NW-WGT_BITS){1'b0}}, wsel};
      default: b_op = '0;
    endcase
    b_bit = b_op[idx_q];
  end

  // the shared adder
  always_comb begin
    add_a = '0;
    add_b = '0;
    cin   = 1'b0;
    case (state_q)
      ST_MUL: begin
        // msb first; the sign bit of the multiplier carries negative weight
        add_a = first_q ? '0 : {prod_q[AW-2:0], 1'b0};
        add_b = b_bit ? (first_q ? ~a_op : a_op) : '0;
        cin   = b_bit && first_q;
      end
      ST_ACC: begin
        add_a = uop.clr ? '0 : acc_q;
        add_b = uop.neg ? ~prod_q : prod_q;
        cin   = uop.neg;
      end
      ST_DSUB: begin
        add_a = nsq_q;
        add_b = ~num_sel;
        cin   = 1'b1;
      end
      ST_DIT: begin
        add_a = {acc_q[AW-2:0], 1'b0};
        add_b = ~nsq_q;
        cin   = 1'b1;
      end
      ST_RND: begin
        add_a = acc_q;
        add_b = AW'(RND_HALF);
      end
      default: begin
        add_a = '0;
      end
    endcase
    sum = add_a + add_b + AW'(cin);
  end

  // rounded velocity, saturated to the coordinate range
  always_comb begin
    shifted = sum[AW-1:WGT_FRAC];
    if ((&shifted[SW-1:C-1]) || !(|shifted[SW-1:C-1])) begin
      vsat = shifted[C-1:0];
    end else if (shifted[SW-1]) begin
      vsat = {1'b1, {(C-1){1'b0}}};
    end else begin
      vsat = {1'b0, {(C-1){1'b1}}};
    end
    wb_lim = WGT_ONE - wa_q;
    wb_new = (wb_q > wb_lim) ? wb_lim : wb_q;
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_acc && (command_i == CMD_INTERP)) state_d = ST_MUL;
      end
      ST_MUL: begin
        if (idx_q == '0) state_d = ST_ACC;
      end
      ST_ACC: begin
        if (!uop.wr) begin
          state_d = ST_MUL;
        end else begin
          case (uop.dst)
            DS_NSQ:  state_d = ST_CHECK;
            DS_NUM:  state_d = (uop.d_idx == 2'd1) ? ST_DSUB : ST_MUL;
            DS_VEL:  state_d = ST_RND;
            default: state_d = ST_MUL;
          endcase
        end
      end
      ST_CHECK: state_d = nsq_zero ? ST_DONE : ST_MUL;
      ST_DSUB:  state_d = ST_DCHK;
      ST_DCHK: begin
        if (num_le0 || rem_le0) begin
          state_d = div_sel_q ? ST_WFIN : ST_DSUB;
        end else begin
          state_d = ST_DIT;
        end
      end
      ST_DIT: begin
        if (cnt_q == '0) state_d = div_sel_q ? ST_WFIN : ST_DSUB;
      end
      ST_WFIN: state_d = ST_MUL;
      ST_RND:  state_d = (uop.d_idx == 2'd2) ? ST_DONE : ST_MUL;
      ST_DONE: begin
        if (out_load) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // sequencer counters
  always_comb begin
    enter_mul = (state_d == ST_MUL) && (state_q != ST_MUL);
    k_d       = k_q;
    if (enter_mul) begin
      if (state_q == ST_IDLE) begin
        k_d = '0;
      end else if (state_q == ST_WFIN) begin
        k_d = K_VEL_FIRST;
      end else begin
        k_d = k_q + K_BITS'(1);
      end
    end
    case (uop_nxt.b_grp)
      BG_N:    idx_top = IW'(NW - 1);
      BG_W:    idx_top = IW'(WGT_BITS);
      default: idx_top = IW'(D - 1);
    endcase
    idx_d   = idx_q;
    first_d = 1'b0;
    if (enter_mul) begin
      idx_d   = idx_top;
      first_d = 1'b1;
    end else if (state_q == ST_MUL) begin
      idx_d = idx_q - IW'(1);
    end
    div_sel_d = div_sel_q;
    if (state_q == ST_ACC) begin
      div_sel_d = 1'b0;
    end else if (state_d == ST_DSUB) begin
      div_sel_d = 1'b1;
    end
    cnt_d = cnt_q;
    quo_d = {quo_q[WGT_FRAC-2:0], ~sum[AW-1]};
    if (state_q == ST_DCHK) begin
      cnt_d = 4'(WGT_FRAC - 1);
    end else if (state_q == ST_DIT) begin
      cnt_d = cnt_q - 4'd1;
    end
    out_valid_d = out_valid_q && out_stall_i;
    if (out_load) out_valid_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      k_q         <= '0;
      idx_q       <= '0;
      first_q     <= 1'b0;
      div_sel_q   <= 1'b0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      k_q         <= k_d;
      idx_q       <= idx_d;
      first_q     <= first_d;
      div_sel_q   <= div_sel_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  // corner store and datapath registers
  always_ff @(posedge clk_i) begin
    if (in_acc && (corner_i != CORNER_NONE)) begin
      if (command_i == CMD_LOAD_POS) begin
        pos_q[corner_i][0] <= coord_x_i;
        pos_q[corner_i][1] <= coord_y_i;
        pos_q[corner_i][2] <= coord_z_i;
      end else if (command_i == CMD_LOAD_VEL) begin
        vst_q[corner_i][0] <= coord_x_i;
        vst_q[corner_i][1] <= coord_y_i;
        vst_q[corner_i][2] <= coord_z_i;
      end
    end
    if (in_acc && (command_i == CMD_INTERP)) begin
      p_q[0] <= coord_x_i;
      p_q[1] <= coord_y_i;
      p_q[2] <= coord_z_i;
    end
    case (state_q)
      ST_MUL: prod_q <= sum;
      ST_ACC: begin
        acc_q <= sum;
        if (uop.wr) begin
          case (uop.dst)
            DS_N:    n_q[uop.d_idx] <= sum[NW-1:0];
            DS_NSQ:  nsq_q <= sum;
            DS_M:    m_q[uop.d_idx] <= sum[MW-1:0];
            DS_NUM:  num_q[uop.d_idx[0]] <= sum;
            default: begin
            end
          endcase
        end
      end
      ST_CHECK: begin
        deg_q <= nsq_zero;
        if (nsq_zero) begin
          vel_q[0] <= vst_q[0][0];
          vel_q[1] <= vst_q[0][1];
          vel_q[2] <= vst_q[0][2];
          wa_q     <= WGT_ONE;
          wb_q     <= '0;
          wc_q     <= '0;
        end
      end
      ST_DSUB: acc_q <= sum;
      ST_DCHK: begin
        quo_q <= '0;
        if (num_le0) begin
          if (div_sel_q) wb_q <= WGT_ONE;
          else           wa_q <= WGT_ONE;
        end else if (rem_le0) begin
          if (div_sel_q) wb_q <= '0;
          else           wa_q <= '0;
        end
      end
      ST_DIT: begin
        quo_q <= quo_d;
        if (!sum[AW-1]) acc_q <= sum;
        else            acc_q <= {acc_q[AW-2:0], 1'b0};
        if (cnt_q == '0) begin
          if (div_sel_q) wb_q <= {1'b0, quo_d};
          else           wa_q <= {1'b0, quo_d};
        end
      end
      ST_WFIN: begin
        wb_q <= wb_new;
        wc_q <= wb_lim - wb_new;
      end
      ST_RND: vel_q[uop.d_idx] <= vsat;
      default: begin
      end
    endcase
    if (out_load) begin
      ovel_q[0] <= vel_q[0];
      ovel_q[1] <= vel_q[1];
      ovel_q[2] <= vel_q[2];
      owa_q     <= wa_q;
      owb_q     <= wb_q;
      owc_q     <= wc_q;
      odeg_q    <= deg_q;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign vel_x_o      = ovel_q[0];
  assign vel_y_o      = ovel_q[1];
  assign vel_z_o      = ovel_q[2];
  assign weight_a_o   = owa_q;
  assign weight_b_o   = owb_q;
  assign weight_c_o   = owc_q;
  assign degenerate_o = odeg_q;

  a_weight_sum : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ({2'b00, weight_a_o} + {2'b00, weight_b_o} + {2'b00, weight_c_o})
                    == {2'b00, WGT_ONE})
    else $error("result weights do not sum to one");

  a_degenerate : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && degenerate_o) |-> (weight_a_o == WGT_ONE) && (weight_b_o == '0))
    else $error("degenerate result with wrong weights");

  a_interp_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o && (command_i == CMD_INTERP)) |=> in_stall_o)
    else $error("interpolate request did not start the sequencer");

  a_prog_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_MUL) |-> (k_q <= K_LAST))
    else $error("program index past the last product");

  a_done_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == ST_DONE) && out_valid_q && out_stall_i) |=> (state_q == ST_DONE))
    else $error("finished result overwrote a pending output");

endmodule
